FILE: rtl/bsw_pkg.sv
// Shared constants for the B-spline weight and gradient unit.
// No dependencies.
package bsw_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic CFG_KERNEL_MODE   = 1'b0;
    localparam logic CFG_INV_CELL_SIZE = 1'b1;

    localparam logic [23:0] INV_CELL_SIZE_RST = 24'd65536;

    // Kernel modes
    localparam logic KM_QUAD  = 1'b0;
    localparam logic KM_CUBIC = 1'b1;

    // Kernel regions of one axis offset
    localparam logic [1:0] RG_INNER = 2'd0;
    localparam logic [1:0] RG_OUTER = 2'd1;
    localparam logic [1:0] RG_ZERO  = 2'd2;

    // floor(v / 6) = (v * DIV6_M) >> DIV6_K, exact for v < 2^26
    localparam int          DIV6_K = 29;
    localparam logic [26:0] DIV6_M = 27'd89478486;

    localparam logic [16:0] WEIGHT_MAX = 17'h1FFFF;

endpackage

FILE: rtl/bsw_if.sv
// Item channels of the B-spline weight and gradient unit.
// No dependencies.
interface bsw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] part_x;
    logic [31:0] part_y;
    logic [31:0] part_z;
    logic [31:0] node_x;
    logic [31:0] node_y;
    logic [31:0] node_z;

    modport source (output valid, part_x, part_y, part_z, node_x, node_y, node_z,
                    input ready);
    modport sink   (input valid, part_x, part_y, part_z, node_x, node_y, node_z,
                    output ready);
endinterface

interface bsw_out_if;
    logic               valid;
    logic               ready;
    logic        [16:0] weight;
    logic signed [25:0] grad_x;
    logic signed [25:0] grad_y;
    logic signed [25:0] grad_z;

    modport source (output valid, weight, grad_x, grad_y, grad_z, input ready);
    modport sink   (input valid, weight, grad_x, grad_y, grad_z, output ready);
endinterface

FILE: rtl/bsw_axis.sv
// One axis: offset scaling and kernel / derivative evaluation, six stages.
// Depends on bsw_pkg.
module bsw_axis
    import bsw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic [5:0]           i_en,
    input  logic [31:0]          i_part,
    input  logic [31:0]          i_node,
    input  logic                 i_mode,
    input  logic [23:0]          i_inv,
    output logic [FRAC_BITS:0]   o_w,
    output logic [FRAC_BITS:0]   o_d,
    output logic                 o_dneg
);
    localparam int F  = FRAC_BITS;
    localparam int UW = F + 2;
    localparam logic [UW-1:0] ONE_U    = UW'(1) << F;
    localparam logic [UW-1:0] HALF_U   = UW'(1) << (F - 1);
    localparam logic [UW-1:0] THREEH_U = ONE_U + HALF_U;
    localparam logic [UW-1:0] TWO_U    = UW'(2) << F;
    localparam logic [55:0]   TWO_P    = 56'(2) << F;
    localparam logic [F:0]    QTR3     = (F+1)'((3 << F) >> 2);
    localparam logic [F+2:0]  C23      = (F+3)'((2 << F) / 3);
    localparam logic [F+2:0]  FOUR     = (F+3)'(4) << F;

    // stage 1: |part - node|
    logic [31:0] r1_diff;
    logic        r1_neg;
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_neg  <= i_part < i_node;
            r1_diff <= (i_part < i_node) ? (i_node - i_part) : (i_part - i_node);
        end
    end

    // stage 2: scale by reciprocal cell size
    logic [55:0] r2_prod;
    logic        r2_neg;
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_prod <= 56'(r1_diff) * 56'(i_inv);
            r2_neg  <= r1_neg;
        end
    end

    // stage 3: saturate, pick region, square
    logic [55:0]    hi;
    logic [UW-1:0]  u, a_q, a_c;
    logic [F:0]     m;
    logic [1:0]     rg;
    logic [F-1:0]   um;
    logic [F+2:0]   lin;
    logic [2*F+1:0] p_sq;
    logic [2*F+2:0] p_dm;
    always_comb begin
        hi  = r2_prod >> F;
        u   = (hi > TWO_P) ? TWO_U : hi[UW-1:0];
        a_q = THREEH_U - u;
        a_c = TWO_U - u;
        if (i_mode == KM_QUAD) begin
            if (u < HALF_U) begin
                rg = RG_INNER; m = u[F:0];
            end else if (u < THREEH_U) begin
                rg = RG_OUTER; m = a_q[F:0];
            end else begin
                rg = RG_ZERO;  m = '0;
            end
        end else begin
            if (u < ONE_U) begin
                rg = RG_INNER; m = u[F:0];
            end else if (u < TWO_U) begin
                rg = RG_OUTER; m = a_c[F:0];
            end else begin
                rg = RG_ZERO;  m = '0;
            end
        end
        um   = (i_mode == KM_CUBIC && rg == RG_INNER) ? u[F-1:0] : '0;
        lin  = FOUR - (F+3)'(3) * (F+3)'(um);
        p_sq = (2*F+2)'(m) * (2*F+2)'(m);
        p_dm = (2*F+3)'(um) * (2*F+3)'(lin);
    end

    logic [F:0] r3_m, r3_sq, r3_dm;
    logic [1:0] r3_rg;
    logic       r3_mode, r3_neg;
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_m    <= m;
            r3_sq   <= p_sq[2*F:F];
            r3_dm   <= p_dm[2*F:F];
            r3_rg   <= rg;
            r3_mode <= i_mode;
            r3_neg  <= r2_neg;
        end
    end

    // stage 4: cube
    logic [2*F+1:0] p_cb;
    assign p_cb = (2*F+2)'(r3_sq) * (2*F+2)'(r3_m);

    logic [F:0] r4_m, r4_sq, r4_dm, r4_cb;
    logic [1:0] r4_rg;
    logic       r4_mode, r4_neg;
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_m    <= r3_m;
            r4_sq   <= r3_sq;
            r4_dm   <= r3_dm;
            r4_cb   <= p_cb[2*F:F];
            r4_rg   <= r3_rg;
            r4_mode <= r3_mode;
            r4_neg  <= r3_neg;
        end
    end

    // stage 5: kernel value and derivative per branch; cubic tail starts /6
    logic [F+2:0] ci;
    logic [F:0]   wv, dv;
    always_comb begin
        ci = (F+3)'(r4_cb >> 1) - (F+3)'(r4_sq) + C23;
        wv = '0;
        dv = '0;
        if (r4_mode == KM_QUAD) begin
            if (r4_rg == RG_INNER) begin
                wv = QTR3 - r4_sq;
                dv = {r4_m[F-1:0], 1'b0};
            end else if (r4_rg == RG_OUTER) begin
                wv = r4_sq >> 1;
                dv = r4_m;
            end
        end else begin
            if (r4_rg == RG_INNER) begin
                wv = ci[F+2] ? '0 : ci[F:0];
                dv = r4_dm >> 1;
            end else if (r4_rg == RG_OUTER) begin
                dv = r4_sq >> 1;
            end
        end
    end

    logic [DIV6_K+F:0] r5_divp;
    logic [F:0]        r5_w, r5_d;
    logic              r5_isdiv, r5_neg;
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_divp  <= (DIV6_K+F+1)'(r4_cb) * (DIV6_K+F+1)'(DIV6_M);
            r5_w     <= wv;
            r5_d     <= dv;
            r5_isdiv <= r4_mode == KM_CUBIC && r4_rg == RG_OUTER;
            r5_neg   <= r4_neg;
        end
    end

    // stage 6: finish; derivative is -sign(x) times magnitude
    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            o_w    <= r5_isdiv ? r5_divp[DIV6_K+F:DIV6_K] : r5_w;
            o_d    <= r5_d;
            o_dneg <= !r5_neg;
        end
    end

endmodule

FILE: rtl/bspline_weight_and_gradient_unit.sv
// B-spline weight and gradient unit, top level.
// Depends on bsw_pkg, bsw_if (bsw_in_if, bsw_out_if) and bsw_axis.
//
//  channel    dir  handshake          payload
//  i_item     in   valid / ready      part_x/y/z, node_x/y/z (Q16.16)
//  o_result   out  valid / ready      weight (Q1.16), grad_x/y/z (Q9.16)
//  i_cfg_*    in   i_cfg_we only      i_cfg_idx, i_cfg_data
//
// Nine register stages, one item per cycle while the output is not stalled.
// Six stages per axis (difference, scale, square, cube, branch / divide by 6,
// finish), then three for the products and gradient scaling.
// Reset clears valid bits and config only. Each stage holds only when it is
// full and the next one holds, so bubbles collapse under output stall and no
// item is lost or repeated.
module bspline_weight_and_gradient_unit
    import bsw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    bsw_in_if.sink      i_item,
    bsw_out_if.source   o_result
);
    localparam int F  = FRAC_BITS;
    localparam int NS = 9;

    // config
    logic        r_kernel_mode;
    logic [23:0] r_inv_cell_size;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode   <= KM_QUAD;
            r_inv_cell_size <= INV_CELL_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KERNEL_MODE:   r_kernel_mode   <= i_cfg_data[0];
                CFG_INV_CELL_SIZE: r_inv_cell_size <= i_cfg_data;
            endcase
        end
    end

    // stage valids and per-stage advance
    logic [NS-1:0] r_vld, en;
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_result.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_item.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign i_item.ready = en[0];

    // per-axis kernel evaluation, stages 1..6
    logic [F:0] w0, w1, w2, d0, d1, d2;
    logic       dn0, dn1, dn2;

    bsw_axis #(.FRAC_BITS(F)) u_ax_x (
        .i_clk(i_clk), .i_en(en[5:0]), .i_part(i_item.part_x), .i_node(i_item.node_x),
        .i_mode(r_kernel_mode), .i_inv(r_inv_cell_size),
        .o_w(w0), .o_d(d0), .o_dneg(dn0)
    );
    bsw_axis #(.FRAC_BITS(F)) u_ax_y (
        .i_clk(i_clk), .i_en(en[5:0]), .i_part(i_item.part_y), .i_node(i_item.node_y),
        .i_mode(r_kernel_mode), .i_inv(r_inv_cell_size),
        .o_w(w1), .o_d(d1), .o_dneg(dn1)
    );
    bsw_axis #(.FRAC_BITS(F)) u_ax_z (
        .i_clk(i_clk), .i_en(en[5:0]), .i_part(i_item.part_z), .i_node(i_item.node_z),
        .i_mode(r_kernel_mode), .i_inv(r_inv_cell_size),
        .o_w(w2), .o_d(d2), .o_dneg(dn2)
    );

    // stage 7: first pairwise products
    logic [2*F+1:0] p01, ptx, pty, ptz;
    assign p01 = (2*F+2)'(w0) * (2*F+2)'(w1);
    assign ptx = (2*F+2)'(d0) * (2*F+2)'(w1);
    assign pty = (2*F+2)'(d1) * (2*F+2)'(w0);
    assign ptz = (2*F+2)'(d2) * (2*F+2)'(w0);

    logic [F:0] r7_w01, r7_tx, r7_ty, r7_tz, r7_w1, r7_w2;
    logic [2:0] r7_dn;
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r7_w01 <= p01[2*F:F];
            r7_tx  <= ptx[2*F:F];
            r7_ty  <= pty[2*F:F];
            r7_tz  <= ptz[2*F:F];
            r7_w1  <= w1;
            r7_w2  <= w2;
            r7_dn  <= {dn2, dn1, dn0};
        end
    end

    // stage 8: products with the third axis value
    logic [2*F+1:0] pw, pmx, pmy, pmz;
    assign pw  = (2*F+2)'(r7_w01) * (2*F+2)'(r7_w2);
    assign pmx = (2*F+2)'(r7_tx)  * (2*F+2)'(r7_w2);
    assign pmy = (2*F+2)'(r7_ty)  * (2*F+2)'(r7_w2);
    assign pmz = (2*F+2)'(r7_tz)  * (2*F+2)'(r7_w1);

    logic [F:0] r8_wt, r8_mx, r8_my, r8_mz;
    logic [2:0] r8_dn;
    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r8_wt <= pw[2*F:F];
            r8_mx <= pmx[2*F:F];
            r8_my <= pmy[2*F:F];
            r8_mz <= pmz[2*F:F];
            r8_dn <= r7_dn;
        end
    end

    // stage 9: scale by reciprocal cell size, apply sign, clamp weight.
    // Magnitudes are at most one, so a scaled gradient stays below 2^24 and
    // the Q9.16 range is never exceeded.
    logic [F+24:0] pgx, pgy, pgz;
    logic [25:0]   gx, gy, gz;
    assign pgx = (F+25)'(r8_mx) * (F+25)'(r_inv_cell_size);
    assign pgy = (F+25)'(r8_my) * (F+25)'(r_inv_cell_size);
    assign pgz = (F+25)'(r8_mz) * (F+25)'(r_inv_cell_size);
    assign gx  = 26'(pgx[F+24:F]);
    assign gy  = 26'(pgy[F+24:F]);
    assign gz  = 26'(pgz[F+24:F]);

    logic [16:0]        r9_wt;
    logic signed [25:0] r9_gx, r9_gy, r9_gz;
    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r9_wt <= (32'(r8_wt) > 32'(WEIGHT_MAX)) ? WEIGHT_MAX : 17'(r8_wt);
            r9_gx <= r8_dn[0] ? -$signed(gx) : $signed(gx);
            r9_gy <= r8_dn[1] ? -$signed(gy) : $signed(gy);
            r9_gz <= r8_dn[2] ? -$signed(gz) : $signed(gz);
        end
    end

    assign o_result.valid  = r_vld[NS-1];
    assign o_result.weight = r9_wt;
    assign o_result.grad_x = r9_gx;
    assign o_result.grad_y = r9_gy;
    assign o_result.grad_z = r9_gz;

endmodule

FILE: bench/bsw_checker.sv
// Checker for the B-spline weight and gradient unit: predicts each result from
// the accepted input items and compares it with the output channel.
// Depends on bsw_pkg.
`timescale 1ns / 1ps
module bsw_checker
    import bsw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [31:0] i_px, i_py, i_pz, i_nx, i_ny, i_nz,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [16:0] i_weight,
    input  logic [25:0] i_gx, i_gy, i_gz,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);
    localparam int F = FRAC_BITS_DEF;
    localparam longint ONE = 64'sd1 << F;

    typedef struct packed {
        logic [16:0] weight;
        logic [25:0] gx, gy, gz;
    } t_bsw_result;

    t_bsw_result weight_grad_q[$];
    logic        mode;
    logic [23:0] inv_cs;

    function automatic longint fmul(longint a, longint b);
        return longint'(($unsigned(a) * $unsigned(b)) >> F);
    endfunction

    function automatic void eval_axis(input logic [31:0] p, input logic [31:0] n,
                                      output longint w, output longint d,
                                      output bit dneg);
        longint unsigned diff, uu;
        longint u, a, a2, u2, u3;
        diff = (p < n) ? 64'(n - p) : 64'(p - n);
        uu = (diff * inv_cs) >> F;
        u = (uu > 2 * ONE) ? 2 * ONE : longint'(uu);
        w = 0; d = 0;
        if (mode == KM_QUAD) begin
            if (u < ONE / 2) begin
                w = (3 * ONE) / 4 - fmul(u, u);
                d = 2 * u;
            end else if (u < ONE + ONE / 2) begin
                a = ONE + ONE / 2 - u;
                w = fmul(a, a) >>> 1;
                d = a;
            end
        end else begin
            if (u < ONE) begin
                u2 = fmul(u, u);
                u3 = fmul(u2, u);
                w = (u3 >>> 1) - u2 + (2 * ONE) / 3;
                d = fmul(u, 4 * ONE - 3 * u) >>> 1;
            end else if (u < 2 * ONE) begin
                a = 2 * ONE - u;
                a2 = fmul(a, a);
                w = fmul(a2, a) / 6;
                d = a2 >>> 1;
            end
        end
        if (w < 0) w = 0;
        if (d < 0) d = 0;
        dneg = !(p < n);
    endfunction

    function automatic logic [25:0] grad_comp(longint d, bit dneg, longint wa, longint wb);
        longint g;
        g = fmul(fmul(fmul(d, wa), wb), longint'(inv_cs));
        if (dneg) g = -g;
        if (g > (64'sd1 << 25) - 1) g = (64'sd1 << 25) - 1;
        if (g < -(64'sd1 << 25)) g = -(64'sd1 << 25);
        return g[25:0];
    endfunction

    function automatic t_bsw_result predict_weight_grad(logic [31:0] px, py, pz,
                                                        logic [31:0] nx, ny, nz);
        longint w0, w1, w2, d0, d1, d2, wt;
        bit n0, n1, n2;
        t_bsw_result r;
        eval_axis(px, nx, w0, d0, n0);
        eval_axis(py, ny, w1, d1, n1);
        eval_axis(pz, nz, w2, d2, n2);
        wt = fmul(fmul(w0, w1), w2);
        if (wt > 64'h1FFFF) wt = 64'h1FFFF;
        r.weight = wt[16:0];
        r.gx = grad_comp(d0, n0, w1, w2);
        r.gy = grad_comp(d1, n1, w0, w2);
        r.gz = grad_comp(d2, n2, w0, w1);
        return r;
    endfunction

    assign o_pending = weight_grad_q.size();

    always @(posedge i_clk) begin
        t_bsw_result exp_r, act_r;
        if (!i_rst_n) begin
            mode <= KM_QUAD;
            inv_cs <= INV_CELL_SIZE_RST;
            o_errors <= 0;
            o_results <= 0;
            weight_grad_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                weight_grad_q.push_back(predict_weight_grad(i_px, i_py, i_pz,
                                                            i_nx, i_ny, i_nz));
            if (i_out_valid && i_out_ready) begin
                act_r = '{i_weight, i_gx, i_gy, i_gz};
                o_results <= o_results + 1;
                if (weight_grad_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, act_r);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = weight_grad_q.pop_front();
                    if (exp_r !== act_r) begin
                        $display("%0t: mismatch exp w=%0d g=%0d,%0d,%0d act w=%0d g=%0d,%0d,%0d",
                                 $time, exp_r.weight, $signed(exp_r.gx), $signed(exp_r.gy),
                                 $signed(exp_r.gz), act_r.weight, $signed(act_r.gx),
                                 $signed(act_r.gy), $signed(act_r.gz));
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_KERNEL_MODE) mode <= i_cfg_data[0];
                else inv_cs <= i_cfg_data;
            end
        end
    end
endmodule

FILE: bench/bspline_weight_and_gradient_unit_tb.sv
// Testbench top for the B-spline weight and gradient unit: clock, reset,
// register writes, directed and random pair stimulus, output backpressure.
// Depends on bsw_pkg, bsw_if, bsw_checker and the unit itself.
`timescale 1ns / 1ps
module bspline_weight_and_gradient_unit_tb;
    import bsw_pkg::*;

    localparam int LATENCY  = 9;
    localparam int WD_LIMIT = 20000;   // idle-cycle watchdog

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_KERNEL_MODE;
    logic [23:0] i_cfg_data = '0;

    bsw_in_if  item_ch ();
    bsw_out_if res_ch ();

    int errors, pending, results;
    int items_sent;
    bit gaps_on = 1'b1;     // random idling enabled
    bit hold_req = 1'b0;    // request a long output stall
    int watchdog = 0;

    always #6 i_clk = ~i_clk;

    bspline_weight_and_gradient_unit dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_item(item_ch.sink), .o_result(res_ch.source)
    );

    bsw_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(item_ch.valid), .i_in_ready(item_ch.ready),
        .i_px(item_ch.part_x), .i_py(item_ch.part_y), .i_pz(item_ch.part_z),
        .i_nx(item_ch.node_x), .i_ny(item_ch.node_y), .i_nz(item_ch.node_z),
        .i_out_valid(res_ch.valid), .i_out_ready(res_ch.ready),
        .i_weight(res_ch.weight), .i_gx(res_ch.grad_x), .i_gy(res_ch.grad_y),
        .i_gz(res_ch.grad_z),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        item_ch.valid = 1'b0;
        {item_ch.part_x, item_ch.part_y, item_ch.part_z} = '0;
        {item_ch.node_x, item_ch.node_y, item_ch.node_z} = '0;
        res_ch.ready = 1'b0;
    end

    // Receiver: random stall bursts, plus one long hold on request.
    initial begin
        int burst;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 19);
                res_ch.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_pair(input logic [31:0] px, py, pz, nx, ny, nz);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.part_x <= px; item_ch.part_y <= py; item_ch.part_z <= pz;
        item_ch.node_x <= nx; item_ch.node_y <= ny; item_ch.node_z <= nz;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offset of a few cells around the node, occasionally far away.
    function automatic logic [31:0] near(logic [31:0] n, logic [23:0] ics);
        logic [31:0] span;
        if ($urandom_range(0, 15) == 0) return $urandom;
        span = (ics > 24'd4096) ? 32'((64'd3 << 32) / ics) : 32'hFFFF_FFFF;
        if (span == 0) span = 1;
        if ($urandom_range(0, 1)) return n + $urandom_range(0, span);
        return n - $urandom_range(0, span);
    endfunction

    logic [23:0] ics_set [6] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd131072, 24'd32768,
                                 24'd0};

    initial begin
        logic [31:0] n0, n1, n2;
        logic [23:0] ics;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero offset, field extremes, region boundaries, far pairs.
        for (int m = 0; m < 2; m++) begin
            write_reg(CFG_KERNEL_MODE, 24'(m ? KM_CUBIC : KM_QUAD));
            write_reg(CFG_INV_CELL_SIZE, 24'd65536);
            send_pair(0, 0, 0, 0, 0, 0);
            send_pair('1, '1, '1, '1, '1, '1);
            send_pair('1, 0, 32'h8000, 0, '1, 0);
            send_pair(32'h8000, 32'h18000, 32'h10000, 0, 0, 0);
            send_pair(0, 0, 0, 32'h7FFF, 32'h17FFF, 32'h1FFFF);
            send_pair(32'h20000, 32'h4000, 32'hC000, 0, 0, 0);
            send_pair(32'h4000, 32'h4000, 32'h4000, 0, 0, 0);
            send_pair(0, 0, 0, 32'h4000, 32'h4000, 32'h4000);
            send_pair(32'h5555_AAAA, 32'hAAAA_5555, 32'h1234_5678,
                      32'h5555_AAAA, 32'hAAAA_5555, 32'h1234_5670);
            drain();
            write_reg(CFG_INV_CELL_SIZE, 24'd0);
            send_pair(32'h100, 32'hFFFF0000, 7, 0, 0, 9);
            drain();
            write_reg(CFG_INV_CELL_SIZE, 24'hFFFFFF);
            send_pair(32'h1, 32'h0, 32'h2, 32'h0, 32'h1, 32'h0);
            drain();
        end

        // Long output hold while input keeps offering.
        hold_req = 1'b1;

        // Random phases over register settings.
        for (int ph = 0; ph < 12; ph++) begin
            ics = (ph < 6) ? ics_set[ph] : 24'($urandom_range(1, 24'hFFFFFF));
            if (ph == 11) gaps_on = 1'b0;
            drain();
            write_reg(CFG_KERNEL_MODE, 24'(ph[0] ? KM_CUBIC : KM_QUAD));
            write_reg(CFG_INV_CELL_SIZE, ics);
            for (int k = 0; k < 75; k++) begin
                n0 = $urandom; n1 = $urandom; n2 = $urandom;
                if ($urandom_range(0, 9) == 0)
                    send_pair($urandom, $urandom, $urandom, n0, n1, n2);
                else
                    send_pair(near(n0, ics), near(n1, ics), near(n2, ics), n0, n1, n2);
            end
        end
        drain();

        $display("Sent %0d particle-node pairs over both kernels and %0d cell sizes;",
                 items_sent, 12);
        $display("checked %0d results including saturation, far and zero-scale cases.",
                 results);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: bspline_weight_and_gradient_unit.f
rtl/bsw_pkg.sv
rtl/bsw_if.sv
rtl/bsw_axis.sv
rtl/bspline_weight_and_gradient_unit.sv
bench/bsw_checker.sv
bench/bspline_weight_and_gradient_unit_tb.sv
